// ===== hw/rtl/sha256md_pkg.sv =====
// shared types, constants and round and schedule functions for the sha-256 digest unit
`default_nettype none

package sha256md_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  // padding progress: marker byte, zero fill, length bytes
  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN
  } pad_phase_t;

  // input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  // result word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // control for the block buffer / schedule
  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       shift_word;
  } sched_ctrl_t;

  // control for the round unit and chain value
  typedef struct packed {
    logic       init_hash;
    logic       load_vars;
    logic       do_round;
    logic       add_chain;
    logic [5:0] round_idx;
    logic [2:0] rd_idx;
  } round_ctrl_t;

  localparam int unsigned NUM_ROUNDS = 64;
  localparam logic [5:0]  LAST_ROUND = 6'(NUM_ROUNDS - 1);
  localparam logic [5:0]  BLOCK_LAST = 6'd63;
  localparam logic [5:0]  LEN_START  = 6'd56;
  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [2:0]  LAST_WORD  = 3'd7;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // round compression sigmas
  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // message schedule sigmas
  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sha256md_sched.sv =====
// block buffer that packs message bytes and rolls the message schedule
`default_nettype none

module sha256md_sched (
  input  wire logic                      clk,
  input  wire sha256md_pkg::sched_ctrl_t ctrl,
  output logic [31:0]                    w_cur
);

  logic [31:0] w_r   [16];
  logic [31:0] w_nxt [16];
  logic [31:0] w_new;

  // next schedule word from the sliding window
  assign w_new = w_r[0] + sha256md_pkg::small_sigma0(w_r[1]) + w_r[9]
               + sha256md_pkg::small_sigma1(w_r[14]);

  // byte shift packs big-endian, word shift advances the window
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      w_nxt[i] = w_r[i];
    end
    if (ctrl.shift_byte) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = {w_r[i][23:0], w_r[i+1][31:24]};
      end
      w_nxt[15] = {w_r[15][23:0], ctrl.byte_val};
    end else if (ctrl.shift_word) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = w_r[i+1];
      end
      w_nxt[15] = w_new;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      w_r[i] <= w_nxt[i];
    end
  end

  assign w_cur = w_r[0];

endmodule

`default_nettype wire

// ===== hw/rtl/sha256md_round.sv =====
// shared round unit with working variables and chain value
`default_nettype none

module sha256md_round (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire sha256md_pkg::round_ctrl_t ctrl,
  input  wire logic [31:0]               w_cur,
  output logic [31:0]                    hash_word
);

  logic [31:0] h_r [8];
  logic [31:0] h_nxt [8];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch_val;
  logic [31:0] maj_val;

  // one compression round
  assign ch_val  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj_val = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1 = v_r[7] + sha256md_pkg::big_sigma1(v_r[4]) + ch_val
            + sha256md_pkg::K_TABLE[ctrl.round_idx] + w_cur;
  assign t2 = sha256md_pkg::big_sigma0(v_r[0]) + maj_val;

  // working variables
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      v_nxt[i] = v_r[i];
    end
    if (ctrl.load_vars) begin
      for (int i = 0; i < 8; i++) begin
        v_nxt[i] = h_r[i];
      end
    end else if (ctrl.do_round) begin
      v_nxt[0] = t1 + t2;
      v_nxt[1] = v_r[0];
      v_nxt[2] = v_r[1];
      v_nxt[3] = v_r[2];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[5] = v_r[4];
      v_nxt[6] = v_r[5];
      v_nxt[7] = v_r[6];
    end
  end

  // chain value: restart or fold in the block result
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      h_nxt[i] = h_r[i];
      if (ctrl.init_hash) begin
        h_nxt[i] = sha256md_pkg::H_INIT[i];
      end else if (ctrl.add_chain) begin
        h_nxt[i] = h_r[i] + v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      if (!rst_n) begin
        h_r[i] <= sha256md_pkg::H_INIT[i];
      end else begin
        h_r[i] <= h_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      v_r[i] <= v_nxt[i];
    end
  end

  assign hash_word = h_r[ctrl.rd_idx];

endmodule

`default_nettype wire

// ===== hw/rtl/sha256_message_digest_unit.sv =====
// top level of the sha-256 digest unit: sequencer, padding and handshakes
// Takes one message byte per input word with byte_valid set and returns the eight
// SHA-256 digest words after the end-of-message word. A byte word is taken while
// the unit is idle; the word that completes a 64-byte block then holds the input
// stalled through the load, 64 rounds through the single round unit and the
// chain update. At end of message the padder inserts 9 to 72 bytes at one per
// cycle, runs one or two more compressions, then presents the eight digest
// words, one per cycle while out_stall is low. The input stays stalled from
// end of message until the last digest word is taken; the unit then starts
// a new message from the initial hash values.
`default_nettype none

module sha256_message_digest_unit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire sha256md_pkg::in_item_t  in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output sha256md_pkg::out_item_t      out_data
);

  sha256md_pkg::state_t      state_r, state_nxt;
  sha256md_pkg::pad_phase_t  phase_r, phase_nxt;
  sha256md_pkg::sched_ctrl_t sched_ctrl;
  sha256md_pkg::round_ctrl_t round_ctrl;

  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] count_r, count_nxt;
  logic [5:0]  rcnt_r, rcnt_nxt;
  logic [2:0]  emit_idx_r, emit_idx_nxt;
  logic        eom_r, eom_nxt;
  logic        done_r, done_nxt;

  logic        in_acc;
  logic        out_acc;
  logic        emit_end;
  logic        put_en;
  logic [7:0]  put_byte;
  logic        fill_full;
  logic        is_len;
  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  logic [31:0] w_cur;
  logic [31:0] hash_word;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign emit_end  = out_acc && (emit_idx_r == sha256md_pkg::LAST_WORD);
  assign fill_full = (fill_r == sha256md_pkg::BLOCK_LAST);

  // length field bytes, most significant first
  assign len_bits = {count_r, 3'b000};
  assign len_byte = 8'(len_bits >> {~fill_r[2:0], 3'b000});
  assign is_len   = (phase_r == sha256md_pkg::PAD_LEN)
                 || ((phase_r == sha256md_pkg::PAD_ZERO) && (fill_r == sha256md_pkg::LEN_START));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha256md_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.byte_valid && fill_full) begin
            state_nxt = sha256md_pkg::ST_LOAD;
          end else if (in_data.end_of_message) begin
            state_nxt = sha256md_pkg::ST_PAD;
          end
        end
      end
      sha256md_pkg::ST_PAD: begin
        if (fill_full) begin
          state_nxt = sha256md_pkg::ST_LOAD;
        end
      end
      sha256md_pkg::ST_LOAD:  state_nxt = sha256md_pkg::ST_ROUND;
      sha256md_pkg::ST_ROUND: begin
        if (rcnt_r == sha256md_pkg::LAST_ROUND) begin
          state_nxt = sha256md_pkg::ST_FINAL;
        end
      end
      sha256md_pkg::ST_FINAL: begin
        if (done_r) begin
          state_nxt = sha256md_pkg::ST_EMIT;
        end else if (eom_r) begin
          state_nxt = sha256md_pkg::ST_PAD;
        end else begin
          state_nxt = sha256md_pkg::ST_IDLE;
        end
      end
      sha256md_pkg::ST_EMIT: begin
        if (emit_end) begin
          state_nxt = sha256md_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha256md_pkg::ST_IDLE;
    endcase
  end

  // outputs and unit controls
  always_comb begin
    in_stall  = (state_r != sha256md_pkg::ST_IDLE);
    out_valid = (state_r == sha256md_pkg::ST_EMIT);
    put_en    = 1'b0;
    put_byte  = in_data.data_byte;
    case (state_r)
      sha256md_pkg::ST_IDLE: begin
        put_en = in_acc && in_data.byte_valid;
      end
      sha256md_pkg::ST_PAD: begin
        put_en = 1'b1;
        if (phase_r == sha256md_pkg::PAD_MARK) begin
          put_byte = sha256md_pkg::PAD_BYTE;
        end else if (is_len) begin
          put_byte = len_byte;
        end else begin
          put_byte = 8'h00;
        end
      end
      default: begin
        put_en = 1'b0;
      end
    endcase
    sched_ctrl.shift_byte = put_en;
    sched_ctrl.byte_val   = put_byte;
    sched_ctrl.shift_word = (state_r == sha256md_pkg::ST_ROUND);
    round_ctrl.init_hash  = emit_end;
    round_ctrl.load_vars  = (state_r == sha256md_pkg::ST_LOAD);
    round_ctrl.do_round   = (state_r == sha256md_pkg::ST_ROUND);
    round_ctrl.add_chain  = (state_r == sha256md_pkg::ST_FINAL);
    round_ctrl.round_idx  = rcnt_r;
    round_ctrl.rd_idx     = emit_idx_r;
  end

  // counters and padding bookkeeping
  always_comb begin
    fill_nxt     = put_en ? fill_r + 6'd1 : fill_r;
    count_nxt    = count_r;
    eom_nxt      = eom_r;
    phase_nxt    = phase_r;
    done_nxt     = done_r;
    rcnt_nxt     = rcnt_r;
    emit_idx_nxt = out_acc ? emit_idx_r + 3'd1 : emit_idx_r;
    if (in_acc) begin
      eom_nxt = in_data.end_of_message;
      if (in_data.byte_valid) begin
        count_nxt = count_r + 61'd1;
      end
    end
    if (state_r == sha256md_pkg::ST_PAD) begin
      if (phase_r == sha256md_pkg::PAD_MARK) begin
        phase_nxt = sha256md_pkg::PAD_ZERO;
      end else if (is_len) begin
        phase_nxt = sha256md_pkg::PAD_LEN;
        if (fill_full) begin
          done_nxt = 1'b1;
        end
      end
    end
    if (state_r == sha256md_pkg::ST_LOAD) begin
      rcnt_nxt = '0;
    end else if (state_r == sha256md_pkg::ST_ROUND) begin
      rcnt_nxt = rcnt_r + 6'd1;
    end
    if (emit_end) begin
      count_nxt = '0;
      eom_nxt   = 1'b0;
      phase_nxt = sha256md_pkg::PAD_MARK;
      done_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sha256md_pkg::ST_IDLE;
      phase_r    <= sha256md_pkg::PAD_MARK;
      fill_r     <= '0;
      count_r    <= '0;
      rcnt_r     <= '0;
      emit_idx_r <= '0;
      eom_r      <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      fill_r     <= fill_nxt;
      count_r    <= count_nxt;
      rcnt_r     <= rcnt_nxt;
      emit_idx_r <= emit_idx_nxt;
      eom_r      <= eom_nxt;
      done_r     <= done_nxt;
    end
  end

  sha256md_sched u_sched (
    .clk   (clk),
    .ctrl  (sched_ctrl),
    .w_cur (w_cur)
  );

  sha256md_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (round_ctrl),
    .w_cur     (w_cur),
    .hash_word (hash_word)
  );

  // result word
  always_comb begin
    out_data.digest_word = hash_word;
    out_data.word_index  = emit_idx_r;
    out_data.last_word   = (emit_idx_r == sha256md_pkg::LAST_WORD);
  end

  // a full block always starts a compression
  a_full_block_compresses: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.byte_valid && fill_full) |=> (state_r == sha256md_pkg::ST_LOAD))
    else $error("full block did not start compression");

  // input is never taken while digest words are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input ready while digest pending");

  // digest words only appear on a block boundary
  a_emit_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha256md_pkg::ST_EMIT) |-> (fill_r == '0))
    else $error("digest output with partial block");

  // the last word clears the message state
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    emit_end |=> (count_r == '0 && !eom_r && state_r == sha256md_pkg::ST_IDLE))
    else $error("message state not cleared after digest");

  // the round loop ends after exactly the last round
  a_round_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha256md_pkg::ST_ROUND && rcnt_r == sha256md_pkg::LAST_ROUND)
      |=> (state_r == sha256md_pkg::ST_FINAL))
    else $error("round loop did not finish");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the sha-256 message digest unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam int TAIL_WORDS  = 25;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 60;
  localparam int DRAIN_WAIT  = 100;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  sha256md_pkg::in_item_t  in_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  sha256md_pkg::out_item_t out_data;

  // words waiting to be sent and digest words waiting to come out
  sha256md_pkg::in_item_t  msg_words [$];
  sha256md_pkg::out_item_t pending_digest [$];

  // predicted hash state
  logic [31:0] chain_h [8];
  logic [31:0] blk_w [16];
  logic [60:0] msg_len;
  int          blk_fill;

  int mismatch_count = 0;
  int words_taken = 0;
  int tx_gap = 0;
  int tx_calm = 0;
  int rx_gap = 0;
  int rx_calm = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  sha256_message_digest_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_digest();
    chain_h  = SHA_IV;
    msg_len  = '0;
    blk_fill = 0;
  endfunction

  // shift one byte into the block, run the 64 rounds once it is full
  function automatic void absorb_byte(input logic [7:0] b);
    logic [31:0] w [64];
    logic [31:0] a, bb, c, d, e, f, g, h, t1, t2, s0, s1;
    int t;
    blk_w[blk_fill / 4] = {blk_w[blk_fill / 4][23:0], b};
    blk_fill = blk_fill + 1;
    if (blk_fill == 64) begin
      blk_fill = 0;
      for (t = 0; t < 64; t++) begin
        if (t < 16) begin
          w[t] = blk_w[t];
        end else begin
          s0 = rotr32(w[t-15], 7) ^ rotr32(w[t-15], 18) ^ (w[t-15] >> 3);
          s1 = rotr32(w[t-2], 17) ^ rotr32(w[t-2], 19) ^ (w[t-2] >> 10);
          w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
      end
      a = chain_h[0]; bb = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (t = 0; t < 64; t++) begin
        t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) + ((e & f) ^ (~e & g))
             + ROUND_K[t] + w[t];
        t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) + ((a & bb) ^ (a & c) ^ (bb & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = bb; bb = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += bb; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    end
  endfunction

  // expected digest words for one accepted input word
  function automatic void predict_item(input sha256md_pkg::in_item_t it);
    logic [63:0]             bit_len;
    sha256md_pkg::out_item_t dw;
    int                      i;
    if (it.byte_valid) begin
      absorb_byte(it.data_byte);
      msg_len = msg_len + 61'd1;
    end
    if (!it.end_of_message) return;
    bit_len = {msg_len, 3'b000};
    absorb_byte(8'h80);
    while (blk_fill != 56) absorb_byte(8'h00);
    for (i = 7; i >= 0; i--) absorb_byte(bit_len[8*i +: 8]);
    for (i = 0; i < 8; i++) begin
      dw.digest_word = chain_h[i];
      dw.word_index  = 3'(i);
      dw.last_word   = (i == 7);
      pending_digest.push_back(dw);
    end
    restart_digest();
  endfunction

  function automatic bit in_tail();
    return msg_words.size() < TAIL_WORDS;
  endfunction

  function automatic void push_word(input logic [7:0] d, input logic v, input logic e);
    sha256md_pkg::in_item_t w;
    w = '{d, v, e};
    msg_words.push_back(w);
  endfunction

  // one message of random bytes with the odd skipped word mixed in
  task automatic queue_message(input int len);
    bit eom_on_byte;
    int i;
    eom_on_byte = 1'($urandom_range(0, 1));
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) push_word(8'($urandom), 1'b0, 1'b0);
      push_word(8'($urandom), 1'b1, eom_on_byte && (i == len - 1));
    end
    if (len == 0 || !eom_on_byte) push_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // input driver: predicts on every accepted word, idles in bursts
  always @(posedge clk) begin : drive_input
    sha256md_pkg::in_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(in_data);
        words_taken <= words_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (msg_words.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!in_tail() && tx_calm == 0 && $urandom_range(0, 4) == 0) begin
          tx_gap   <= $urandom_range(0, 12);
          in_valid <= 1'b0;
          if ($urandom_range(0, 5) == 0) tx_calm <= $urandom_range(20, 60);
        end else begin
          nxt = msg_words.pop_front();
          in_data  <= nxt;
          in_valid <= 1'b1;
          if (tx_calm != 0) tx_calm <= tx_calm - 1;
        end
      end
    end
  end

  // one long receiver hold-off so the unit backs up into its input
  always @(posedge clk) begin : long_hold
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_taken >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // output monitor: compares each digest word, stalls in bursts
  always @(posedge clk) begin : watch_output
    sha256md_pkg::out_item_t want;
    int                      g;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_digest.size() == 0) begin
        report_mismatch("digest word with none expected", out_data.digest_word, '0);
      end else begin
        want = pending_digest.pop_front();
        if (out_data.digest_word !== want.digest_word)
          report_mismatch("digest_word", out_data.digest_word, want.digest_word);
        if (out_data.word_index !== want.word_index)
          report_mismatch("word_index", 32'(out_data.word_index), 32'(want.word_index));
        if (out_data.last_word !== want.last_word)
          report_mismatch("last_word", 32'(out_data.last_word), 32'(want.last_word));
      end
    end
    g = rx_gap;
    if (g != 0) begin
      g = g - 1;
    end else if (!in_tail() && rx_calm == 0 && $urandom_range(0, 4) == 0) begin
      g = $urandom_range(1, 13);
      if ($urandom_range(0, 5) == 0) rx_calm <= $urandom_range(20, 60);
    end else if (rx_calm != 0) begin
      rx_calm <= rx_calm - 1;
    end
    rx_gap    <= g;
    out_stall <= (g != 0) || (hold_left != 0);
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    int lens [$];
    int total, j, k, tmp;
    restart_digest();

    // empty message, data on the end word ignored
    push_word(8'ha5, 1'b0, 1'b1);
    // skipped word, then a single byte carried by the end word
    push_word(8'hff, 1'b0, 1'b0);
    push_word(8'hff, 1'b1, 1'b1);
    // zero byte followed by a separate end word
    push_word(8'h00, 1'b1, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);
    // "abc" with a skipped word in the middle
    push_word(8'h61, 1'b1, 1'b0);
    push_word(8'h5a, 1'b0, 1'b0);
    push_word(8'h62, 1'b1, 1'b0);
    push_word(8'h63, 1'b1, 1'b1);
    // bytes around the padding marker value
    push_word(8'h80, 1'b1, 1'b0);
    push_word(8'h7f, 1'b1, 1'b0);
    push_word(8'h01, 1'b1, 1'b0);
    push_word(8'hfe, 1'b1, 1'b0);
    push_word(8'hff, 1'b0, 1'b1);

    // random messages: one near the length field boundary, one near a full block
    lens.push_back(55 + $urandom_range(0, 1));
    lens.push_back(63 + $urandom_range(0, 1));
    total = lens[0] + lens[1] + 2;
    while (total < 190) begin
      k = $urandom_range(0, 14);
      lens.push_back(k);
      total += k + 1;
    end
    for (j = lens.size() - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      tmp = lens[j];
      lens[j] = lens[k];
      lens[k] = tmp;
    end
    for (j = 0; j < lens.size(); j++) queue_message(lens[j]);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (msg_words.size() != 0 || in_valid || pending_digest.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0 && pending_digest.size() == 0) begin
      $display("PASS sha256_message_digest_unit");
    end else begin
      $display("FAIL sha256_message_digest_unit");
    end
    $finish;
  end

  // run limit
  initial begin : run_limit
    #2000000;
    $display("FAIL sha256_message_digest_unit");
    $finish;
  end

endmodule
